/* sv/epk_pkg.sv */
// Shared types and constants of the ellipse outline pick block.
package epk_pkg;

  localparam int DW = 64;

  localparam logic signed [13:0] COORD_MIN = -14'sd8192;
  localparam logic signed [13:0] COORD_MAX = 14'sd8191;

  localparam logic CFG_ENTRY_COUNT = 1'b0;
  localparam logic CFG_PICK_TOL    = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic signed [13:0] cx;
    logic signed [13:0] cy;
    logic [12:0]        rx;
    logic [12:0]        ry;
  } entry_t;

endpackage

/* sv/epk_iter.sv */
// Shared iterative unit: restoring floor square root and truncating division.
module epk_iter
  import epk_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  iter_req_t     req,
  input  logic [DW-1:0] opa,
  input  logic [DW-1:0] opb,
  output logic          done,
  output logic [DW-1:0] res
);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  iter_op_t      op_r, op_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [DW+1:0] rem_r, rem_nxt;
  logic [DW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] root_r, root_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW+1:0] rem_sh;
  logic [DW+1:0] trial;
  logic          ge;

  // One compare and subtract is shared by both operations.
  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_sh = {rem_r[DW-1:0], acc_r[DW-1:DW-2]};
      trial  = {root_r, 2'b01};
    end else begin
      rem_sh = {rem_r[DW:0], acc_r[DW-1]};
      trial  = {2'b00, den_r};
    end
    ge = rem_sh >= trial;
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    root_nxt = root_r;
    den_nxt  = den_r;
    if (req.start) begin
      run_nxt  = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = (req.op == OP_SQRT) ? 7'(DW / 2) : 7'(DW);
      rem_nxt  = '0;
      acc_nxt  = opa;
      root_nxt = '0;
      den_nxt  = opb;
    end else if (run_r) begin
      rem_nxt  = ge ? rem_sh - trial : rem_sh;
      root_nxt = {root_r[DW-2:0], ge};
      acc_nxt  = (op_r == OP_SQRT) ? {acc_r[DW-3:0], 2'b00} : {acc_r[DW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_SQRT;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign res  = root_r;

endmodule

/* sv/epk_table.sv */
// Ellipse table memory: one write port and one registered read port.
module epk_table
  import epk_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IW      = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/ellipse_outline_pick.sv */
// Top level of the ellipse outline pick block: sequencer, multiplier and registers.
// The block keeps a table of axis-aligned ellipses and picks the first one whose
// outline passes near a query point. An input word is taken at a rising edge with
// start high and busy low. A word of kind zero writes one table entry in that same
// edge, gives no result and leaves busy low. A word of kind one starts a query: busy
// rises and the table is scanned from entry zero up to the entry count. With an entry
// count of zero busy stays low and a miss result follows with no scan. Each entry costs
// a table read, up to ten multiplier steps and up to five passes of the shared root and
// divide unit. That shared unit, working one bit per cycle, sets the rate.
// The result word appears on the out_ ports for exactly one cycle, marked by
// out_valid, in the cycle after the query finishes; busy is low in that cycle.
// The receiver cannot stall, so a result is never held back.
// Configuration writes on cfg_we take effect at once and are meant for idle times.
// Reset clears the control state, sets the entry count to zero and the pick
// tolerance to three; the table contents stay undefined until written.
module ellipse_outline_pick
  import epk_pkg::*;
#(
  parameter int ENTRIES       = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [5:0]          in_slot,
  input  logic signed [13:0]  in_center_x,
  input  logic signed [13:0]  in_center_y,
  input  logic [12:0]         in_radius_x,
  input  logic [12:0]         in_radius_y,
  input  logic signed [13:0]  in_probe_x,
  input  logic signed [13:0]  in_probe_y,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  output logic                out_valid,
  output logic                out_hit,
  output logic [5:0]          out_hit_index,
  output logic signed [13:0]  out_near_x,
  output logic signed [13:0]  out_near_y
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [DW-1:0] HALF = DW'(1) << (FRACTION_BITS - 1);

  // Sequencer states, one hot.
  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_RD   = 20'h00002,
    S_DIF  = 20'h00004,
    S_M1   = 20'h00008,
    S_M2   = 20'h00010,
    S_WDIS = 20'h00020,
    S_M3   = 20'h00040,
    S_M4   = 20'h00080,
    S_M5   = 20'h00100,
    S_M6   = 20'h00200,
    S_WDEN = 20'h00400,
    S_M7   = 20'h00800,
    S_M8   = 20'h01000,
    S_WRAD = 20'h02000,
    S_CMP  = 20'h04000,
    S_M9   = 20'h08000,
    S_WOFX = 20'h10000,
    S_M10  = 20'h20000,
    S_WOFY = 20'h40000,
    S_NEXT = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]         count_r;
  logic [7:0]         tol_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic signed [13:0] px_r, py_r;
  entry_t             ent_r, ent_nxt;
  logic [13:0]        ax_r, ax_nxt, ay_r, ay_nxt;
  logic               sx_r, sx_nxt, sy_r, sy_nxt;
  logic [DW-1:0]      acc_r, acc_nxt;
  logic [31:0]        u_r, u_nxt;
  logic [31:0]        dis_r, dis_nxt;
  logic [DW-1:0]      den_r, den_nxt;
  logic [DW-1:0]      rad_r, rad_nxt;
  logic signed [13:0] nx_r, nx_nxt;

  logic               ov_r, ov_nxt;
  logic               oh_r, oh_nxt;
  logic [5:0]         oi_r, oi_nxt;
  logic signed [13:0] onx_r, onx_nxt, ony_r, ony_nxt;

  logic [31:0]        mul_a, mul_b;
  logic [DW-1:0]      prod;
  logic [DW-1:0]      sum;
  iter_req_t          ireq;
  logic [DW-1:0]      iopa, iopb;
  logic               idone;
  logic [DW-1:0]      ires;
  entry_t             rd_ent;
  entry_t             wr_ent;
  logic               tab_we;
  logic [IW-1:0]      tab_waddr;
  logic [31:0]        scan_n;
  logic               last_entry;
  logic               accept;
  logic signed [14:0] dx, dy;
  logic [DW-1:0]      diff;
  logic [31:0]        idx_w;
  logic [31:0]        slot_w;

  // Offset along one axis, rounded half away from zero, added to the center and
  // clamped to the coordinate range.
  function automatic logic signed [13:0] place(logic signed [13:0] c, logic neg,
                                               logic [DW-1:0] off);
    logic [DW-1:0]      step;
    logic signed [16:0] cw, sw, s;
    logic signed [13:0] r;
    step = (off + HALF) >> FRACTION_BITS;
    cw   = {{3{c[13]}}, c};
    sw   = {3'b000, step[13:0]};
    s    = neg ? cw - sw : cw + sw;
    if (step > DW'(16383)) begin
      r = neg ? COORD_MIN : COORD_MAX;
    end else if (s < 17'sd0 - 17'sd8192) begin
      r = COORD_MIN;
    end else if (s > 17'sd8191) begin
      r = COORD_MAX;
    end else begin
      r = s[13:0];
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign slot_w    = 32'(in_slot);
  assign tab_waddr = slot_w[IW-1:0];
  assign tab_we    = accept && (in_kind == KIND_WRITE) && (slot_w < 32'(ENTRIES));
  assign wr_ent    = '{cx: in_center_x, cy: in_center_y, rx: in_radius_x, ry: in_radius_y};

  epk_table #(.ENTRIES(ENTRIES), .IW(IW)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (wr_ent),
    .re    (state_r == S_RD),
    .raddr (idx_r),
    .rdata (rd_ent)
  );

  epk_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .opa   (iopa),
    .opb   (iopb),
    .done  (idone),
    .res   (ires)
  );

  assign scan_n     = (32'(count_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(count_r);
  assign idx_w      = 32'(idx_r);
  assign last_entry = (idx_w + 32'd1) >= scan_n;
  assign dx         = {px_r[13], px_r} - {rd_ent.cx[13], rd_ent.cx};
  assign dy         = {py_r[13], py_r} - {rd_ent.cy[13], rd_ent.cy};
  assign diff       = (DW'(dis_r) > rad_r) ? DW'(dis_r) - rad_r : rad_r - DW'(dis_r);

  // The single multiplier; its operands follow the sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1:    begin mul_a = 32'(ax_r);      mul_b = 32'(ax_r); end
      S_M2:    begin mul_a = 32'(ay_r);      mul_b = 32'(ay_r); end
      S_M3:    begin mul_a = 32'(ent_r.ry);  mul_b = 32'(ax_r); end
      S_M4:    begin mul_a = u_r;            mul_b = u_r; end
      S_M5:    begin mul_a = 32'(ent_r.rx);  mul_b = 32'(ay_r); end
      S_M6:    begin mul_a = u_r;            mul_b = u_r; end
      S_M7:    begin mul_a = 32'(ent_r.rx);  mul_b = 32'(ent_r.ry); end
      S_M8:    begin mul_a = u_r;            mul_b = dis_r; end
      S_M9:    begin mul_a = rad_r[31:0];    mul_b = 32'(ax_r); end
      S_M10:   begin mul_a = rad_r[31:0];    mul_b = 32'(ay_r); end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  assign prod = DW'(mul_a) * DW'(mul_b);
  assign sum  = acc_r + prod;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ent_nxt   = ent_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    acc_nxt   = acc_r;
    u_nxt     = u_r;
    dis_nxt   = dis_r;
    den_nxt   = den_r;
    rad_nxt   = rad_r;
    nx_nxt    = nx_r;
    ov_nxt    = 1'b0;
    oh_nxt    = oh_r;
    oi_nxt    = oi_r;
    onx_nxt   = onx_r;
    ony_nxt   = ony_r;
    ireq      = '{start: 1'b0, op: OP_SQRT};
    iopa      = '0;
    iopb      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_kind == KIND_QUERY) begin
          idx_nxt = '0;
          if (scan_n == 32'd0) begin
            ov_nxt  = 1'b1;
            oh_nxt  = 1'b0;
            oi_nxt  = '0;
            onx_nxt = '0;
            ony_nxt = '0;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_DIF;
      S_DIF: begin
        ent_nxt   = rd_ent;
        sx_nxt    = dx[14];
        sy_nxt    = dy[14];
        ax_nxt    = dx[14] ? 14'(-dx) : dx[13:0];
        ay_nxt    = dy[14] ? 14'(-dy) : dy[13:0];
        acc_nxt   = '0;
        state_nxt = S_M1;
      end
      S_M1: begin
        acc_nxt   = prod;
        state_nxt = S_M2;
      end
      S_M2: begin
        if (ax_r == '0 && ay_r == '0) begin
          // The probe sits on the center: that entry is hit at its center.
          ov_nxt    = 1'b1;
          oh_nxt    = 1'b1;
          oi_nxt    = idx_w[5:0];
          onx_nxt   = ent_r.cx;
          ony_nxt   = ent_r.cy;
          state_nxt = S_IDLE;
        end else begin
          ireq      = '{start: 1'b1, op: OP_SQRT};
          iopa      = sum << (2 * FRACTION_BITS);
          state_nxt = S_WDIS;
        end
      end
      S_WDIS: begin
        if (idone) begin
          dis_nxt   = ires[31:0];
          state_nxt = S_M3;
        end
      end
      S_M3: begin
        u_nxt     = prod[31:0];
        state_nxt = S_M4;
      end
      S_M4: begin
        acc_nxt   = prod;
        state_nxt = S_M5;
      end
      S_M5: begin
        u_nxt     = prod[31:0];
        state_nxt = S_M6;
      end
      S_M6: begin
        ireq      = '{start: 1'b1, op: OP_SQRT};
        iopa      = sum;
        state_nxt = S_WDEN;
      end
      S_WDEN: begin
        if (idone) begin
          den_nxt   = ires;
          state_nxt = (ires == '0) ? S_NEXT : S_M7;
        end
      end
      S_M7: begin
        u_nxt     = prod[31:0];
        state_nxt = S_M8;
      end
      S_M8: begin
        ireq      = '{start: 1'b1, op: OP_DIV};
        iopa      = prod;
        iopb      = den_r;
        state_nxt = S_WRAD;
      end
      S_WRAD: begin
        if (idone) begin
          rad_nxt   = ires;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (diff > (DW'(tol_r) << FRACTION_BITS)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_M9;
        end
      end
      S_M9: begin
        ireq      = '{start: 1'b1, op: OP_DIV};
        iopa      = prod << FRACTION_BITS;
        iopb      = DW'(dis_r);
        state_nxt = S_WOFX;
      end
      S_WOFX: begin
        if (idone) begin
          nx_nxt    = place(ent_r.cx, sx_r, ires);
          state_nxt = S_M10;
        end
      end
      S_M10: begin
        ireq      = '{start: 1'b1, op: OP_DIV};
        iopa      = prod << FRACTION_BITS;
        iopb      = DW'(dis_r);
        state_nxt = S_WOFY;
      end
      S_WOFY: begin
        if (idone) begin
          ov_nxt    = 1'b1;
          oh_nxt    = 1'b1;
          oi_nxt    = idx_w[5:0];
          onx_nxt   = nx_r;
          ony_nxt   = place(ent_r.cy, sy_r, ires);
          state_nxt = S_IDLE;
        end
      end
      S_NEXT: begin
        if (last_entry) begin
          ov_nxt    = 1'b1;
          oh_nxt    = 1'b0;
          oi_nxt    = '0;
          onx_nxt   = '0;
          ony_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      tol_r   <= 8'd3;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENTRY_COUNT: count_r <= cfg_wdata[6:0];
          CFG_PICK_TOL:    tol_r   <= cfg_wdata;
          default:         ;
        endcase
      end
    end
    if (accept) begin
      px_r <= in_probe_x;
      py_r <= in_probe_y;
    end
    idx_r <= idx_nxt;
    ent_r <= ent_nxt;
    ax_r  <= ax_nxt;
    ay_r  <= ay_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    acc_r <= acc_nxt;
    u_r   <= u_nxt;
    dis_r <= dis_nxt;
    den_r <= den_nxt;
    rad_r <= rad_nxt;
    nx_r  <= nx_nxt;
    oh_r  <= oh_nxt;
    oi_r  <= oi_nxt;
    onx_r <= onx_nxt;
    ony_r <= ony_nxt;
  end

  assign out_valid     = ov_r;
  assign out_hit       = oh_r;
  assign out_hit_index = oi_r;
  assign out_near_x    = onx_r;
  assign out_near_y    = ony_r;

`ifndef SYNTHESIS
  // When a result is shown the scan is over and the block is ready again.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a query is still running");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_index == '0 && out_near_x == '0 &&
                                 out_near_y == '0))
    else $error("miss result with nonzero fields");

  // The shared unit is only started from a step that then waits for it.
  a_iter_start: assert property (@(posedge clk) disable iff (!rst_n)
    ireq.start |=> (state_r == S_WDIS || state_r == S_WDEN || state_r == S_WRAD ||
                    state_r == S_WOFX || state_r == S_WOFY))
    else $error("shared unit started outside a wait step");
`endif

endmodule
